// ===== hdl/exsol_pkg.sv =====
`default_nettype none
package exsol_pkg;

  localparam int CountW = 16;
  localparam int CfgW   = 4;
  localparam int IdxW   = 3;
  localparam int NumW   = 48;
  localparam int DenW   = 27;
  localparam int RootW  = NumW / 2;
  localparam int SqRemW = RootW + 1;
  localparam int ResW   = 32;
  localparam int ProdW  = 31;

  localparam logic [IdxW-1:0] RegIso      = 3'd0;
  localparam logic [IdxW-1:0] RegShutter  = 3'd1;
  localparam logic [IdxW-1:0] RegAperture = 3'd2;
  localparam logic [IdxW-1:0] RegSolveAp  = 3'd3;
  localparam logic [IdxW-1:0] RegIncident = 3'd4;

  function automatic logic [10:0] iso_f(input logic [2:0] idx);
    logic [10:0] v;
    case (idx)
      3'd0: v = 11'd100;
      3'd1: v = 11'd200;
      3'd2: v = 11'd400;
      3'd3: v = 11'd500;
      3'd4: v = 11'd800;
      default: v = 11'd1600;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] shut_f(input logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0: v = 8'd30;
      2'd1: v = 8'd60;
      2'd2: v = 8'd125;
      default: v = 8'd175;
    endcase
    return v;
  endfunction

  // f-number squared times 100
  function automatic logic [15:0] ap2_f(input logic [3:0] idx);
    logic [15:0] v;
    case (idx)
      4'd0: v = 16'd784;
      4'd1: v = 16'd1089;
      4'd2: v = 16'd1600;
      4'd3: v = 16'd2304;
      4'd4: v = 16'd3136;
      4'd5: v = 16'd4489;
      4'd6: v = 16'd6400;
      4'd7: v = 16'd9025;
      4'd8: v = 16'd12100;
      4'd9: v = 16'd16900;
      4'd10: v = 16'd25600;
      default: v = 16'd48400;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/exposure_solver_core.sv =====
// Exposure solver: converts each raw light-sensor count into a shutter denominator or an
// f-number in unsigned 24.8 fixed point. Fully pipelined: one count per cycle while the output
// does not stall, through 3 scaling stages, 48 stages of a restoring divider at one quotient bit
// each, 24 stages of a square root at one root bit each and one output register. Any output stall
// freezes the whole pipeline. Configuration is a plain write port and must only be written
// while no transfer is in flight.
`default_nettype none
module exposure_solver_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [exsol_pkg::IdxW-1:0]    cfg_index,
  input  wire logic [exsol_pkg::CfgW-1:0]    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [exsol_pkg::CountW-1:0]  raw_count,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [exsol_pkg::ResW-1:0]         result_value,
  output logic                               result_is_aperture,
  output logic                               saturated
);
  import exsol_pkg::*;

  logic [2:0] iso_index;
  logic [1:0] shutter_index;
  logic [3:0] aperture_index;
  logic       solve_aperture;
  logic       incident_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      iso_index      <= '0;
      shutter_index  <= '0;
      aperture_index <= '0;
      solve_aperture <= 1'b0;
      incident_mode  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegIso:      iso_index      <= cfg_data[2:0];
        RegShutter:  shutter_index  <= cfg_data[1:0];
        RegAperture: aperture_index <= cfg_data[3:0];
        RegSolveAp:  solve_aperture <= cfg_data[0];
        RegIncident: incident_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // divisor from configuration, refreshed every cycle
  logic [DenW-1:0] den;
  logic [15:0]     den_sel;
  logic [10:0]     den_k;
  always_comb begin
    den_sel = solve_aperture ? {8'd0, shut_f(shutter_index)} : ap2_f(aperture_index);
    den_k   = incident_mode ? 11'd1600 : 11'd12;
  end
  always_ff @(posedge clk) begin
    den <= {11'd0, den_sel} * {16'd0, den_k};
  end

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // scaling stages
  logic              s1_v, s2_v, s3_v;
  logic              s1_ap, s2_ap, s3_ap;
  logic [19:0]       s1_cl;
  logic [ProdW-1:0]  s2_p;
  logic [NumW-1:0]   s3_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else if (adv) begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cl  <= {4'd0, raw_count} * (incident_mode ? 20'd6 : 20'd15);
      s1_ap  <= solve_aperture;
      s2_p   <= {11'd0, s1_cl} * {20'd0, iso_f(iso_index)};
      s2_ap  <= s1_ap;
      s3_num <= s2_ap ? {1'b0, s2_p, 16'd0} : {17'd0, s2_p} * 48'd25600;
      s3_ap  <= s2_ap;
    end
  end

  // restoring divider, one quotient bit per stage
  logic [DenW-1:0] d_r  [0:NumW];
  logic [NumW-1:0] d_n  [0:NumW];
  logic            d_v  [0:NumW];
  logic            d_ap [0:NumW];

  always_comb begin
    d_r[0]  = '0;
    d_n[0]  = s3_num;
    d_v[0]  = s3_v;
    d_ap[0] = s3_ap;
  end

  for (genvar i = 0; i < NumW; i++) begin : g_div
    logic [DenW:0] t;
    logic          ge;
    always_comb begin
      t  = {d_r[i], d_n[i][NumW-1]};
      ge = t >= {1'b0, den};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        d_v[i+1] <= 1'b0;
      end else if (adv) begin
        d_v[i+1] <= d_v[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        d_r[i+1]  <= ge ? DenW'(t - {1'b0, den}) : DenW'(t);
        d_n[i+1]  <= {d_n[i][NumW-2:0], ge};
        d_ap[i+1] <= d_ap[i];
      end
    end
  end

  // square root, one root bit per stage; shutter results pass unchanged
  logic [NumW-1:0]   q_x  [0:RootW];
  logic [SqRemW-1:0] q_r  [0:RootW];
  logic [RootW-1:0]  q_rt [0:RootW];
  logic              q_v  [0:RootW];
  logic              q_ap [0:RootW];

  always_comb begin
    q_x[0]  = d_n[NumW];
    q_r[0]  = '0;
    q_rt[0] = '0;
    q_v[0]  = d_v[NumW];
    q_ap[0] = d_ap[NumW];
  end

  for (genvar j = 0; j < RootW; j++) begin : g_sqrt
    logic [SqRemW+1:0] t;
    logic [SqRemW+1:0] trial;
    logic              ge;
    always_comb begin
      t     = {q_r[j], q_x[j][NumW-1:NumW-2]};
      trial = {1'b0, q_rt[j], 2'b01};
      ge    = t >= trial;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        q_v[j+1] <= 1'b0;
      end else if (adv) begin
        q_v[j+1] <= q_v[j];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        q_ap[j+1] <= q_ap[j];
        if (q_ap[j]) begin
          q_x[j+1]  <= {q_x[j][NumW-3:0], 2'b00};
          q_r[j+1]  <= ge ? SqRemW'(t - trial) : SqRemW'(t);
          q_rt[j+1] <= {q_rt[j][RootW-2:0], ge};
        end else begin
          q_x[j+1]  <= q_x[j];
          q_r[j+1]  <= q_r[j];
          q_rt[j+1] <= q_rt[j];
        end
      end
    end
  end

  // output register
  logic over;
  assign over = !q_ap[RootW] && (q_x[RootW][NumW-1:ResW] != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= q_v[RootW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_is_aperture <= q_ap[RootW];
      saturated          <= over;
      if (q_ap[RootW]) begin
        result_value <= ResW'(q_rt[RootW]);
      end else if (over) begin
        result_value <= '1;
      end else begin
        result_value <= q_x[RootW][ResW-1:0];
      end
    end
  end

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_v)
    else $error("accepted transfer lost at first stage");

  a_ap_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_is_aperture |-> result_value[ResW-1:RootW] == '0 && !saturated)
    else $error("f-number result out of range");

  a_den: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> den != '0)
    else $error("zero divisor");

endmodule
`default_nettype wire
